// ----- rtl/lpbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbc_pkg
// Shared constants, codes and types of the LED PWM and blink controller.
// ----------------------------------------------------------------------------
package lpbc_pkg;

    localparam int NUM_LEDS      = 8;
    localparam int BLINK_UNIT_MS = 10;

    localparam int LED_W     = 8;
    localparam int CMD_W     = 2;
    localparam int ADDR_W    = 8;
    localparam int DATA_W    = 8;
    localparam int NOW_W     = 16;
    localparam int COUNT_W   = 4;
    localparam int LEVEL_W   = 4;
    localparam int PAIR_MAX  = LED_W / 2;
    localparam int NUM_PAIRS = NUM_LEDS / 2;
    localparam int PAIR_IDX_W = $clog2(PAIR_MAX);

    localparam int PERIOD_W  = DATA_W + $clog2(BLINK_UNIT_MS + 1);
    localparam int PROD_W    = PERIOD_W + DATA_W;
    localparam int REM_W     = PERIOD_W + 1;
    localparam int DIV_CNT_W = $clog2(NOW_W);

    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [ADDR_W-1:0] ADDR_COUNT      = 8'd0;
    localparam logic [ADDR_W-1:0] ADDR_STATE      = 8'd1;
    localparam logic [ADDR_W-1:0] ADDR_BRIGHTNESS = 8'd2;
    localparam logic [ADDR_W-1:0] ADDR_BLINK      = 8'd3;
    localparam logic [ADDR_W-1:0] ADDR_PERIOD     = 8'd4;
    localparam logic [ADDR_W-1:0] ADDR_DUTY       = 8'd5;
    localparam logic [ADDR_W-1:0] ADDR_LEVEL_BASE = 8'd6;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL      = 4'hF;
    localparam logic [DATA_W-1:0]  MASTER_FULL     = 8'hFF;
    localparam logic [DATA_W-1:0]  PERIOD_RESET    = 8'd50;
    localparam logic [DATA_W-1:0]  DUTY_RESET      = 8'h80;
    localparam logic [DATA_W-1:0]  LEVEL_PAIR_FULL = 8'hFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_GATE,
        S_RESULT
    } ctl_state_t;

    typedef enum logic [2:0] {
        G_IDLE,
        G_MUL,
        G_DIV,
        G_SCALE,
        G_CMP
    } gate_state_t;

    typedef struct packed {
        logic done;
        logic open;
    } gate_stat_t;

endpackage

// ----- rtl/lpbc_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbc_req_if
// Request channel: valid/ready handshake with command payload.
// ----------------------------------------------------------------------------
interface lpbc_req_if
    import lpbc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] reg_addr;
    logic [DATA_W-1:0] write_data;
    logic [NOW_W-1:0]  now_ms;

    modport source (output valid, cmd, reg_addr, write_data, now_ms, input ready);
    modport sink (input valid, cmd, reg_addr, write_data, now_ms, output ready);
endinterface

// ----- rtl/lpbc_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbc_rsp_if
// Response channel: valid/ready handshake with result payload.
// ----------------------------------------------------------------------------
interface lpbc_rsp_if
    import lpbc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic [LED_W-1:0]  led_out;
    logic              is_static;

    modport source (output valid, read_data, led_out, is_static, input ready);
    modport sink (input valid, read_data, led_out, is_static, output ready);
endinterface

// ----- rtl/lpbc_gate_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpbc_gate_unit
// Blink gate: time modulo period by restoring division, then a duty compare,
// all through one shared subtractor.
// ----------------------------------------------------------------------------
module lpbc_gate_unit
    import lpbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NOW_W-1:0]  now_ms,
    input  logic [DATA_W-1:0] blink_period,
    input  logic [DATA_W-1:0] duty_cfg,
    output gate_stat_t        stat
);

    gate_state_t state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic [PERIOD_W-1:0] period_reg;
    logic [DATA_W-1:0]   duty_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [NOW_W-1:0]    dvd_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [PROD_W-1:0]   scaled_reg;

    logic [REM_W-1:0]  shifted;
    logic [PROD_W-1:0] sub_a;
    logic [PROD_W-1:0] sub_b;
    logic [PROD_W-1:0] diff;
    logic              borrow;

    assign shifted = {rem_reg[PERIOD_W-1:0], dvd_reg[NOW_W-1]};
    assign {borrow, diff} = {1'b0, sub_a} - {1'b0, sub_b};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            G_IDLE:
            begin
                if (start)
                begin
                    state_next = G_MUL;
                end
            end
            G_MUL:
            begin
                state_next = G_DIV;
                cnt_next   = DIV_CNT_W'(NOW_W - 1);
            end
            G_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = G_SCALE;
                end
            end
            G_SCALE:
            begin
                state_next = G_CMP;
            end
            G_CMP:
            begin
                state_next = G_IDLE;
            end
            default:
            begin
                state_next = G_IDLE;
            end
        endcase
    end

    // shared subtractor operand select
    always_comb
    begin
        sub_a     = prod_reg;
        sub_b     = scaled_reg;
        stat.done = 1'b0;
        stat.open = 1'b0;
        case (state_reg)
            G_DIV:
            begin
                sub_a = PROD_W'(shifted);
                sub_b = PROD_W'(period_reg);
            end
            G_SCALE:
            begin
                sub_a = {rem_reg[PERIOD_W-1:0], {DATA_W{1'b0}}};
                sub_b = PROD_W'(rem_reg);
            end
            G_CMP:
            begin
                // open when prod - 255*ph >= 255
                stat.done = 1'b1;
                stat.open = !borrow && ((|diff[PROD_W-1:DATA_W]) || (&diff[DATA_W-1:0]));
            end
            default:
            begin
                sub_a = prod_reg;
                sub_b = scaled_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            G_IDLE:
            begin
                if (start)
                begin
                    period_reg <= PERIOD_W'(blink_period) * PERIOD_W'(BLINK_UNIT_MS);
                    duty_reg   <= duty_cfg;
                    dvd_reg    <= now_ms;
                end
            end
            G_MUL:
            begin
                prod_reg <= PROD_W'(period_reg) * PROD_W'(duty_reg);
                rem_reg  <= '0;
            end
            G_DIV:
            begin
                rem_reg <= borrow ? shifted : diff[REM_W-1:0];
                dvd_reg <= {dvd_reg[NOW_W-2:0], 1'b0};
            end
            G_SCALE:
            begin
                scaled_reg <= diff;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

endmodule

// ----- rtl/led_pwm_blink_controller_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pwm_blink_controller_top
// Register-mapped driver for up to eight LEDs with blink gating, per-LED
// 4-bit dimming and a master brightness PWM.
// ----------------------------------------------------------------------------
// One request is handled at a time and every request gives one response.
// Reads, writes and unused commands pass from the execute state straight to
// the result state. A tick with a nonzero blink period runs the gate unit:
// one multiply step for the duty threshold, then the blink phase, the time
// modulo ten times the period, found by a 16-step restoring divider on the
// gate unit's shared subtractor, then one scale and one compare step; with a
// zero period the gate unit is skipped. A new request is accepted while a
// response waits; its result is held back until the response register is
// free.
// ----------------------------------------------------------------------------
module led_pwm_blink_controller_top
    import lpbc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    lpbc_req_if.sink           req,
    lpbc_rsp_if.source         rsp
);

    ctl_state_t state_reg, state_next;

    logic [COUNT_W-1:0] led_count_reg;
    logic [LED_W-1:0]   on_mask_reg;
    logic [DATA_W-1:0]  master_reg;
    logic [LED_W-1:0]   blink_mask_reg;
    logic [DATA_W-1:0]  period_reg;
    logic [DATA_W-1:0]  duty_reg;
    logic [DATA_W-1:0]  level_pair_reg [PAIR_MAX];
    logic [DATA_W-1:0]  phase_reg;
    logic               gate_open_reg;

    logic [CMD_W-1:0]  cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic [NOW_W-1:0]  now_reg;

    logic              rsp_valid_reg;
    logic [DATA_W-1:0] rsp_rdata_reg;
    logic [LED_W-1:0]  rsp_led_reg;
    logic              rsp_static_reg;

    logic                  accept;
    logic                  gate_start;
    logic                  do_write;
    logic                  load_result;
    gate_stat_t            gate_stat;
    logic                  pair_hit;
    logic [PAIR_IDX_W-1:0] pair_idx;
    logic [LED_W-1:0]      pop_mask;
    logic [DATA_W-1:0]     read_value;
    logic [LED_W-1:0]      tick_leds;
    logic [LED_W-1:0]      lit;
    logic                  static_flag;
    logic [LEVEL_W-1:0]    lvl;

    lpbc_gate_unit u_gate (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (gate_start),
        .now_ms       (now_reg),
        .blink_period (period_reg),
        .duty_cfg     (duty_reg),
        .stat         (gate_stat)
    );

    assign accept = req.valid && req.ready;

    assign pair_hit = (addr_reg >= ADDR_LEVEL_BASE)
                   && (addr_reg < ADDR_LEVEL_BASE + ADDR_W'(NUM_PAIRS));
    assign pair_idx = PAIR_IDX_W'(addr_reg - ADDR_LEVEL_BASE);

    assign pop_mask = (led_count_reg >= COUNT_W'(LED_W)) ? {LED_W{1'b1}}
                    : LED_W'((9'd1 << led_count_reg) - 9'd1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd_reg == CMD_TICK && period_reg != '0)
                begin
                    state_next = S_GATE;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_GATE:
            begin
                if (gate_stat.done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req.ready   = 1'b0;
        gate_start  = 1'b0;
        do_write    = 1'b0;
        load_result = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
            end
            S_EXEC:
            begin
                gate_start = (cmd_reg == CMD_TICK) && (period_reg != '0);
                do_write   = (cmd_reg == CMD_WRITE);
            end
            S_RESULT:
            begin
                // wait for the response register to free up
                load_result = !rsp_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        read_value = '0;
        case (addr_reg)
            ADDR_COUNT:      read_value = DATA_W'(led_count_reg);
            ADDR_STATE:      read_value = on_mask_reg;
            ADDR_BRIGHTNESS: read_value = master_reg;
            ADDR_BLINK:      read_value = blink_mask_reg;
            ADDR_PERIOD:     read_value = period_reg;
            ADDR_DUTY:       read_value = duty_reg;
            default:
            begin
                if (pair_hit)
                begin
                    read_value = level_pair_reg[pair_idx];
                end
            end
        endcase
    end

    // pwm and blink gating of the lit pattern
    always_comb
    begin
        lit = (on_mask_reg & ~blink_mask_reg)
            | (on_mask_reg & blink_mask_reg & {LED_W{gate_open_reg}});
        lvl = '0;
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            lvl = level_pair_reg[i / 2][(i % 2) * LEVEL_W +: LEVEL_W];
            if (lvl != LEVEL_FULL && lvl <= phase_reg[LEVEL_W-1:0])
            begin
                lit[i] = 1'b0;
            end
        end
        tick_leds = (phase_reg < master_reg) ? lit : '0;
    end

    always_comb
    begin
        static_flag = ((blink_mask_reg & on_mask_reg) == '0) && (master_reg == MASTER_FULL);
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            if (on_mask_reg[i]
                && level_pair_reg[i / 2][(i % 2) * LEVEL_W +: LEVEL_W] != LEVEL_FULL)
            begin
                static_flag = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            led_count_reg  <= COUNT_W'(NUM_LEDS);
            on_mask_reg    <= '0;
            master_reg     <= MASTER_FULL;
            blink_mask_reg <= '0;
            period_reg     <= PERIOD_RESET;
            duty_reg       <= DUTY_RESET;
            for (int k = 0; k < PAIR_MAX; k++)
            begin
                level_pair_reg[k] <= LEVEL_PAIR_FULL;
            end
            phase_reg      <= '0;
            gate_open_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                led_count_reg <= (cfg_wr_data > COUNT_W'(NUM_LEDS)) ? COUNT_W'(NUM_LEDS)
                                                                    : cfg_wr_data;
            end

            if (do_write)
            begin
                case (addr_reg)
                    ADDR_STATE:      on_mask_reg    <= wdata_reg & pop_mask;
                    ADDR_BRIGHTNESS: master_reg     <= wdata_reg;
                    ADDR_BLINK:      blink_mask_reg <= wdata_reg & pop_mask;
                    ADDR_PERIOD:     period_reg     <= wdata_reg;
                    ADDR_DUTY:       duty_reg       <= wdata_reg;
                    default:
                    begin
                        if (pair_hit)
                        begin
                            level_pair_reg[pair_idx] <= wdata_reg;
                        end
                    end
                endcase
            end

            // every request opens the gate; a gated tick then sets it, so zero period keeps it open
            if (state_reg == S_EXEC)
            begin
                gate_open_reg <= 1'b1;
            end
            else if (state_reg == S_GATE && gate_stat.done)
            begin
                gate_open_reg <= gate_stat.open;
            end

            if (load_result && cmd_reg == CMD_TICK)
            begin
                phase_reg <= phase_reg + 1'b1;
            end

            if (load_result)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= req.cmd;
            addr_reg  <= req.reg_addr;
            wdata_reg <= req.write_data;
            now_reg   <= req.now_ms;
        end
        if (load_result)
        begin
            rsp_rdata_reg  <= (cmd_reg == CMD_READ) ? read_value : '0;
            rsp_led_reg    <= (cmd_reg == CMD_TICK) ? tick_leds : '0;
            rsp_static_reg <= static_flag;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = rsp_rdata_reg;
    assign rsp.led_out   = rsp_led_reg;
    assign rsp.is_static = rsp_static_reg;

endmodule
